// ----- hdl/ffpra_pkg.sv -----
// Package with the sizes, field widths and status codes of the page run allocator.
package ffpra_pkg;

    localparam int NUM_POOLS   = 4;
    localparam int POOL_PAGES  = 64;
    localparam int TOTAL_PAGES = NUM_POOLS * POOL_PAGES;
    localparam int ADDR_W      = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;

    localparam int POOL_W  = 3;
    localparam int COUNT_W = 7;
    localparam int PAGE_W  = 6;
    localparam int OWNER_W = 8;
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POOL = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_MANY = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_RUN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_PAST_END = 3'd4;

    localparam logic [0:0] ACT_ALLOC = 1'b0;
    localparam logic [0:0] ACT_FREE  = 1'b1;

endpackage

// ----- hdl/ffpra_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
module ffpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- hdl/first_fit_page_run_allocator_unit.sv -----
// Top level of the first-fit page run allocator with its request sequencer.
//
// The block serves allocate and free requests on NUM_POOLS pools of POOL_PAGES
// pages each, one request at a time, and gives exactly one result beat for each
// request beat. An owner byte per page lives in a RAM with a registered read; a
// per-page valid flag in flip-flops, cleared by reset, makes every page read as
// free after reset without any clearing pass. An allocate scans its pool from
// page 0 through the single RAM read port, one page per cycle, looking for the
// first run of page_count free pages, then writes the owner into that run one
// page per cycle through the single write port. A free writes zero over up to
// page_count pages, one per cycle, and stops at the pool end. A request that is
// rejected at once, or has a zero count, goes straight to the response state;
// the others reach it after the last scanned or written page. The response
// state loads the result beat into the output register. s_tready is high only
// while the sequencer is idle; a finished result waits in the output register
// until it is taken, and the next request is accepted meanwhile.
module first_fit_page_run_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata from bit 0 up: action[0], pool[3:1], page_count[10:4],
    // start_offset[16:11], owner_id[24:17], zeros[31:25].
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata from bit 0 up: status[2:0], start_page[8:3], zeros[15:9].
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int PG_W = ffpra_pkg::COUNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    // Fields of the incoming beat.
    logic [0:0]                      in_action;
    logic [ffpra_pkg::POOL_W-1:0]    in_pool;
    logic [ffpra_pkg::COUNT_W-1:0]   in_count;
    logic [ffpra_pkg::PAGE_W-1:0]    in_offset;
    logic [ffpra_pkg::OWNER_W-1:0]   in_owner;

    assign in_action = s_tdata[0];
    assign in_pool   = s_tdata[3:1];
    assign in_count  = s_tdata[10:4];
    assign in_offset = s_tdata[16:11];
    assign in_owner  = s_tdata[24:17];

    logic [2:0]                       state_reg, state_next;
    logic [ffpra_pkg::POOL_W-1:0]     pool_reg, pool_next;
    logic [ffpra_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [ffpra_pkg::OWNER_W-1:0]    owner_reg, owner_next;
    logic [PG_W-1:0]                  pg_reg, pg_next;
    logic [ffpra_pkg::PAGE_W-1:0]     chk_pg_reg, chk_pg_next;
    logic                             chk_valid_reg, chk_valid_next;
    logic [ffpra_pkg::COUNT_W-1:0]    run_reg, run_next;
    logic [ffpra_pkg::COUNT_W-1:0]    rem_reg, rem_next;
    logic [ffpra_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [ffpra_pkg::PAGE_W-1:0]     start_reg, start_next;
    logic                             vbit_reg;
    logic [ffpra_pkg::TOTAL_PAGES-1:0] valid_reg;
    logic                             m_valid_reg, m_valid_next;
    logic [ffpra_pkg::STAT_W-1:0]     m_status_reg, m_status_next;
    logic [ffpra_pkg::PAGE_W-1:0]     m_start_reg, m_start_next;

    logic [ffpra_pkg::ADDR_W-1:0]     page_addr;
    logic                             ram_we;
    logic [ffpra_pkg::OWNER_W-1:0]    ram_wdata;
    logic [ffpra_pkg::OWNER_W-1:0]    ram_rdata;
    logic                             page_free;
    logic [ffpra_pkg::COUNT_W-1:0]    run_inc;
    logic [PG_W:0]                    free_end;

    // One address serves the scan read and the mark or clear write.
    assign page_addr = ffpra_pkg::ADDR_W'(
        ffpra_pkg::ADDR_W'(pool_reg) * ffpra_pkg::ADDR_W'(ffpra_pkg::POOL_PAGES)
        + ffpra_pkg::ADDR_W'(pg_reg[ffpra_pkg::PAGE_W-1:0]));

    assign ram_we    = (state_reg == S_MARK) || (state_reg == S_CLEAR);
    assign ram_wdata = (state_reg == S_MARK) ? owner_reg : '0;

    ffpra_ram #(
        .WIDTH(ffpra_pkg::OWNER_W),
        .DEPTH(ffpra_pkg::TOTAL_PAGES)
    ) u_owner_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(page_addr),
        .wdata(ram_wdata),
        .raddr(page_addr),
        .rdata(ram_rdata)
    );

    // A page never written since reset reads as free through its valid flag.
    assign page_free = !vbit_reg || (ram_rdata == '0);
    assign run_inc   = page_free ? (run_reg + 1'b1) : '0;
    assign free_end  = (PG_W + 1)'(in_offset) + (PG_W + 1)'(in_count);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_start_reg, m_status_reg};

    always_comb begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        count_next     = count_reg;
        owner_next     = owner_reg;
        pg_next        = pg_reg;
        chk_pg_next    = chk_pg_reg;
        chk_valid_next = 1'b0;
        run_next       = run_reg;
        rem_next       = rem_reg;
        status_next    = status_reg;
        start_next     = start_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_start_next   = m_start_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    pool_next   = in_pool;
                    count_next  = in_count;
                    owner_next  = in_owner;
                    run_next    = '0;
                    start_next  = '0;
                    status_next = ffpra_pkg::ST_OK;
                    state_next  = S_RESP;
                    if (4'(in_pool) >= 4'(ffpra_pkg::NUM_POOLS)) begin
                        status_next = ffpra_pkg::ST_BAD_POOL;
                    end else if (in_count > PG_W'(ffpra_pkg::POOL_PAGES)) begin
                        status_next = ffpra_pkg::ST_TOO_MANY;
                    end else if (in_count != '0) begin
                        if (in_action == ffpra_pkg::ACT_ALLOC) begin
                            pg_next    = '0;
                            state_next = S_SCAN;
                        end else begin
                            pg_next  = PG_W'(in_offset);
                            rem_next = in_count;
                            if (free_end > (PG_W + 1)'(ffpra_pkg::POOL_PAGES)) begin
                                status_next = ffpra_pkg::ST_PAST_END;
                            end
                            // An offset beyond the pool leaves nothing to clear.
                            if (PG_W'(in_offset) < PG_W'(ffpra_pkg::POOL_PAGES)) begin
                                state_next = S_CLEAR;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                // Issue the next read while the previous page's data comes back.
                if (pg_reg < PG_W'(ffpra_pkg::POOL_PAGES)) begin
                    chk_valid_next = 1'b1;
                    chk_pg_next    = pg_reg[ffpra_pkg::PAGE_W-1:0];
                    pg_next        = pg_reg + 1'b1;
                end
                if (chk_valid_reg) begin
                    run_next = run_inc;
                    if (run_inc == count_reg) begin
                        pg_next = PG_W'(chk_pg_reg) + 1'b1 - count_reg;
                        start_next = pg_next[ffpra_pkg::PAGE_W-1:0];
                        rem_next   = count_reg;
                        state_next = S_MARK;
                    end else if (PG_W'(chk_pg_reg) == PG_W'(ffpra_pkg::POOL_PAGES - 1)) begin
                        status_next = ffpra_pkg::ST_NO_RUN;
                        state_next  = S_RESP;
                    end
                end
            end
            S_MARK: begin
                pg_next  = pg_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if (rem_reg == PG_W'(1)) begin
                    state_next = S_RESP;
                end
            end
            S_CLEAR: begin
                pg_next  = pg_reg + 1'b1;
                rem_next = rem_reg - 1'b1;
                if ((rem_reg == PG_W'(1))
                    || (pg_reg == PG_W'(ffpra_pkg::POOL_PAGES - 1))) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_start_next  = start_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
            if (state_reg == S_MARK) begin
                valid_reg[page_addr] <= 1'b1;
            end else if (state_reg == S_CLEAR) begin
                valid_reg[page_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pool_reg     <= pool_next;
        count_reg    <= count_next;
        owner_reg    <= owner_next;
        pg_reg       <= pg_next;
        chk_pg_reg   <= chk_pg_next;
        run_reg      <= run_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        start_reg    <= start_next;
        vbit_reg     <= valid_reg[page_addr];
        m_status_reg <= m_status_next;
        m_start_reg  <= m_start_next;
    end

    // A failed request, of either action, never reports a start page.
    a_start_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ffpra_pkg::ST_OK)) |-> (m_start_reg == '0))
        else $error("nonzero start page on a result that is not an allocation");

    // The free run being counted never grows past the requested count.
    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (run_reg < count_reg))
        else $error("scan run length reached the count without leaving the scan");

    // Marking and clearing stay inside the pool.
    a_write_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_MARK) || (state_reg == S_CLEAR))
        |-> (pg_reg < PG_W'(ffpra_pkg::POOL_PAGES)))
        else $error("page write beyond the end of the pool");

    // Entering the mark phase always starts at the recorded start page.
    a_mark_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SCAN) && (state_next == S_MARK))
        |=> (pg_reg == PG_W'(start_reg)))
        else $error("mark phase does not begin at the found start page");

endmodule

// ----- verif/first_fit_page_run_allocator_unit_tb.sv -----
// Self-checking testbench for the first-fit page run allocator with a queue-fed driver.
`timescale 1ns / 1ps

module first_fit_page_run_allocator_unit_tb;

    // Generous ceiling on the run. The slowest legal item costs a full scan and a
    // full mark in the block plus the longest sender gap and receiver stall.
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int RANDOM_ITEMS = 1425;
    localparam int GAP_MAX      = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 140;

    // One request beat as the generator sees it, plus its pacing.
    typedef struct packed {
        logic [0:0]                    action;
        logic [ffpra_pkg::POOL_W-1:0]  pool;
        logic [ffpra_pkg::COUNT_W-1:0] page_count;
        logic [ffpra_pkg::PAGE_W-1:0]  start_offset;
        logic [ffpra_pkg::OWNER_W-1:0] owner_id;
        logic [4:0]                    gap;
        logic                          drain_first;
    } page_req_t;

    // One result beat.
    typedef struct packed {
        logic [ffpra_pkg::STAT_W-1:0] status;
        logic [ffpra_pkg::PAGE_W-1:0] start_page;
    } page_reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    first_fit_page_run_allocator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Requests waiting to be driven, and the replies predicted for accepted requests.
    page_req_t   req_q[$];
    page_reply_t reply_q[$];

    // Our own copy of every page's owner byte, updated in acceptance order.
    logic [ffpra_pkg::OWNER_W-1:0] owner_mirror [ffpra_pkg::TOTAL_PAGES];

    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;
    int unsigned acc_total   = 0;
    int unsigned res_total   = 0;
    int unsigned total_items = 0;

    // Handshakes seen at the last rising edge, read by the falling-edge processes.
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    // Long receiver hold-off, counted in its own process.
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 300;

    // Works out the reply of one request and applies its effect on the owner
    // mirror. Pool is checked first, then the count, for both actions.
    function automatic page_reply_t serve_request(page_req_t rq);
        page_reply_t res;
        int base;
        int run;
        int pg;
        int first;
        int i;
        res.status     = ffpra_pkg::ST_OK;
        res.start_page = '0;
        if (int'(rq.pool) >= ffpra_pkg::NUM_POOLS) begin
            res.status = ffpra_pkg::ST_BAD_POOL;
            return res;
        end
        if (int'(rq.page_count) > ffpra_pkg::POOL_PAGES) begin
            res.status = ffpra_pkg::ST_TOO_MANY;
            return res;
        end
        base = int'(rq.pool) * ffpra_pkg::POOL_PAGES;
        if (rq.action == ffpra_pkg::ACT_ALLOC) begin
            // First fit: a run counter that restarts on every owned page.
            run = 0;
            pg  = 0;
            while (pg < ffpra_pkg::POOL_PAGES && run < int'(rq.page_count)) begin
                if (owner_mirror[base + pg] == '0) run++;
                else run = 0;
                pg++;
            end
            if (run < int'(rq.page_count)) begin
                res.status = ffpra_pkg::ST_NO_RUN;
                return res;
            end
            first = pg - int'(rq.page_count);
            for (i = 0; i < int'(rq.page_count); i++) begin
                owner_mirror[base + first + i] = rq.owner_id;
            end
            res.start_page = first[ffpra_pkg::PAGE_W-1:0];
        end else if (rq.page_count != '0) begin
            // Pages beyond the pool end are skipped, never spilled into the next pool.
            for (i = 0; i < int'(rq.page_count); i++) begin
                if (int'(rq.start_offset) + i < ffpra_pkg::POOL_PAGES) begin
                    owner_mirror[base + int'(rq.start_offset) + i] = '0;
                end
            end
            if (int'(rq.start_offset) + int'(rq.page_count) > ffpra_pkg::POOL_PAGES) begin
                res.status = ffpra_pkg::ST_PAST_END;
            end
        end
        return res;
    endfunction

    task automatic add_req(input logic [0:0] act, input int pl, input int cnt, input int off,
                           input int own, input int gap, input bit drain);
        page_req_t rq;
        rq.action       = act;
        rq.pool         = pl[ffpra_pkg::POOL_W-1:0];
        rq.page_count   = cnt[ffpra_pkg::COUNT_W-1:0];
        rq.start_offset = off[ffpra_pkg::PAGE_W-1:0];
        rq.owner_id     = own[ffpra_pkg::OWNER_W-1:0];
        rq.gap          = gap[4:0];
        rq.drain_first  = drain;
        req_q.push_back(rq);
        total_items++;
    endtask

    // Rising edge: record handshakes, predict accepted requests, check result beats.
    always @(posedge aclk) begin : monitor
        page_req_t   rq;
        page_reply_t want;
        in_fire  <= aresetn && s_tvalid && s_tready;
        out_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            rq.action       = s_tdata[0];
            rq.pool         = s_tdata[3:1];
            rq.page_count   = s_tdata[10:4];
            rq.start_offset = s_tdata[16:11];
            rq.owner_id     = s_tdata[24:17];
            rq.gap          = '0;
            rq.drain_first  = 1'b0;
            reply_q.push_back(serve_request(rq));
            acc_total++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            res_total++;
            if (reply_q.size() == 0) begin
                $error("result beat with no request pending: m_tdata=%h", m_tdata);
                err_count++;
            end else begin
                want = reply_q.pop_front();
                if (m_tdata[2:0] !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_tdata[2:0]);
                    err_count++;
                end
                if (m_tdata[8:3] !== want.start_page) begin
                    $error("start_page mismatch: expected %0d, actual %0d",
                           want.start_page, m_tdata[8:3]);
                    err_count++;
                end
            end
        end
    end

    // Driver. The current request is taken from the queue, held back for its
    // gap, then offered until a beat is accepted. A request marked to drain
    // first is not even taken until every predicted reply has arrived.
    page_req_t   cur;
    logic        cur_loaded = 1'b0;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin : driver
        logic v;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            v = s_tvalid;
            if (in_fire) begin
                v          = 1'b0;
                cur_loaded = 1'b0;
            end
            if (!v) begin
                if (!cur_loaded && req_q.size() != 0) begin
                    if (!(req_q[0].drain_first && reply_q.size() != 0)) begin
                        cur        = req_q.pop_front();
                        cur_loaded = 1'b1;
                        gap_left   = cur.gap;
                    end
                end
                if (cur_loaded) begin
                    if (gap_left == 0) begin
                        v = 1'b1;
                        s_tdata <= {7'b0, cur.owner_id, cur.start_offset, cur.page_count,
                                    cur.pool, cur.action};
                    end else begin
                        gap_left--;
                    end
                end
            end
            s_tvalid <= v;
        end
    end

    // Long hold-off of the receiver, started at fixed points of the accepted
    // request count so that the output register and sequencer both fill up.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (aresetn && acc_total >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 700;
        end
    end

    // Receiver. After each accepted result it draws a stall; some stretches
    // of the run take results without any stall.
    int unsigned rx_stall = 0;

    always @(negedge aclk) begin : receiver
        logic r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_fire) begin
                rx_stall = (((res_total / 150) % 5) == 4) ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_left > 0) begin
                r = 1'b0;
            end else if (rx_stall > 0) begin
                r = 1'b0;
                rx_stall--;
            end else begin
                r = 1'b1;
            end
            m_tready <= r;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[first_fit_page_run_allocator_unit] ERROR");
            $finish;
        end
    end

    initial begin : sequencer
        int n;
        int sel;
        int pick;
        int act;
        int pl;
        int cnt;
        int off;
        int own;
        int gap;
        foreach (owner_mirror[k]) owner_mirror[k] = '0;

        // Directed part. Pool 0 is filled, punched and refilled to reach the
        // no-run, past-end and owner-zero cases with known outcomes.
        add_req(ffpra_pkg::ACT_ALLOC, 0, 0, 63, 5, 0, 0);    // zero-count allocate lands on page 0
        add_req(ffpra_pkg::ACT_ALLOC, 0, 64, 0, 255, 3, 0);  // whole pool
        add_req(ffpra_pkg::ACT_ALLOC, 0, 1, 0, 1, 0, 0);     // pool full, no run
        add_req(ffpra_pkg::ACT_FREE, 0, 0, 42, 9, 0, 0);     // zero-count free changes nothing
        add_req(ffpra_pkg::ACT_FREE, 0, 64, 63, 9, 5, 0);    // past end, page 63 still cleared
        add_req(ffpra_pkg::ACT_ALLOC, 0, 1, 21, 7, 0, 0);    // finds page 63
        add_req(ffpra_pkg::ACT_FREE, 0, 5, 10, 0, 0, 0);     // hole of five pages at 10
        add_req(ffpra_pkg::ACT_ALLOC, 0, 6, 0, 3, 0, 0);     // hole too short
        add_req(ffpra_pkg::ACT_ALLOC, 0, 5, 0, 0, 0, 0);     // owner zero leaves the hole free
        add_req(ffpra_pkg::ACT_ALLOC, 0, 5, 0, 9, 17, 0);    // so the same hole is found again
        add_req(ffpra_pkg::ACT_FREE, 0, 3, 11, 200, 0, 0);   // free of pages owned by another
        add_req(ffpra_pkg::ACT_FREE, 0, 3, 11, 200, 0, 0);   // and of pages already free
        add_req(ffpra_pkg::ACT_ALLOC, 4, 1, 0, 1, 0, 0);     // bad pools
        add_req(ffpra_pkg::ACT_ALLOC, 7, 127, 63, 255, 0, 0);
        add_req(ffpra_pkg::ACT_FREE, 5, 64, 0, 1, 0, 0);
        add_req(ffpra_pkg::ACT_ALLOC, 1, 65, 0, 1, 0, 0);    // too many pages, both actions
        add_req(ffpra_pkg::ACT_FREE, 2, 127, 63, 1, 0, 0);
        add_req(ffpra_pkg::ACT_ALLOC, 1, 127, 0, 2, 0, 0);
        add_req(ffpra_pkg::ACT_ALLOC, 3, 64, 0, 170, 0, 0);
        add_req(ffpra_pkg::ACT_FREE, 3, 64, 0, 85, 0, 0);    // exact fit free
        add_req(ffpra_pkg::ACT_FREE, 1, 40, 32, 1, 0, 0);    // past end must not touch pool 2
        add_req(ffpra_pkg::ACT_ALLOC, 2, 64, 0, 128, 0, 0);
        add_req(ffpra_pkg::ACT_FREE, 0, 64, 0, 1, 0, 0);
        add_req(ffpra_pkg::ACT_ALLOC, 0, 64, 0, 1, 0, 0);
        add_req(ffpra_pkg::ACT_FREE, 2, 32, 21, 1, 0, 0);

        // Random part: mostly legal requests with small runs, some wide frees to
        // reopen pools, and a little noise from bad pools and oversized counts.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            act  = $urandom_range(0, 1);
            pl   = $urandom_range(0, ffpra_pkg::NUM_POOLS - 1);
            off  = $urandom_range(0, ffpra_pkg::POOL_PAGES - 1);
            own  = $urandom_range(0, 255);
            if (sel < 5) begin
                pl  = $urandom_range(ffpra_pkg::NUM_POOLS, 7);
                cnt = $urandom_range(0, 127);
            end else if (sel < 10) begin
                cnt = $urandom_range(ffpra_pkg::POOL_PAGES + 1, 127);
            end else if (act == ffpra_pkg::ACT_ALLOC) begin
                if (pick < 6) cnt = $urandom_range(1, 8);
                else if (pick < 8) cnt = $urandom_range(0, ffpra_pkg::POOL_PAGES);
                else if (pick < 9) cnt = $urandom_range(9, 32);
                else cnt = $urandom_range(0, 1) ? ffpra_pkg::POOL_PAGES : 0;
            end else begin
                if (pick < 7) begin
                    cnt = $urandom_range(1, 12);
                end else if (pick < 8) begin
                    off = $urandom_range(ffpra_pkg::POOL_PAGES - 16, ffpra_pkg::POOL_PAGES - 1);
                    cnt = $urandom_range(ffpra_pkg::POOL_PAGES - off + 1,
                                         ffpra_pkg::POOL_PAGES);
                end else if (pick < 9) begin
                    cnt = 0;
                end else begin
                    cnt = $urandom_range(13, ffpra_pkg::POOL_PAGES);
                end
            end
            gap = (((n / 150) % 5) == 2) ? 0 : $urandom_range(0, GAP_MAX);
            add_req(act[0:0], pl, cnt, off, own, gap, (n == 0 || n == 600 || n == 1100));
        end

        wait (aresetn == 1'b0);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (acc_total == total_items);
        wait (reply_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("[first_fit_page_run_allocator_unit] OK");
        end else begin
            $display("[first_fit_page_run_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ffpra_pkg.sv
hdl/ffpra_ram.sv
hdl/first_fit_page_run_allocator_unit.sv
verif/first_fit_page_run_allocator_unit_tb.sv
